FILE: rtl/thtc_pkg.sv
// Shared types and constants for the thermistor temperature converter.
package thtc_pkg;

  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_W   = 50;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [31:0] LN2_Q30 = 32'd744261118;
  localparam logic [23:0] R_MAX   = 24'hFFFFFF;
  localparam logic [19:0] Q_MAX   = 20'd1000000;
  localparam logic signed [15:0] T_MAX = 16'sd30000;
  localparam logic signed [15:0] T_MIN = -16'sd30000;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

endpackage

FILE: rtl/thermistor_temperature_converter_unit.sv
// Top level: sample accumulation, register port and conversion sequencer.
// Conversion: after the last sample of a group the sequencer forms the
// numerator, runs two divisions and two log2 passes (a normalise shift and 28
// squarings each) and multiplies for ln, x^2, x^3, B*x and C*x^3. It skips the
// second division when the Steinhart-Hart sum is not positive, and all of these
// for a zero or full-scale sum; the result may then wait on the output register.
// Throughput: one sample per cycle between conversions; no sample is taken
// while a conversion runs. Synchronous reset loads the register reset values
// and clears the sum, count and output valid.
module thermistor_temperature_converter_unit
  import thtc_pkg::*;
#(
  parameter int SAMPLE_COUNT = 15,
  parameter int ADC_BITS     = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [9:0]         in_adc_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_temperature_centi_c,
  output logic [23:0]        out_resistance_ohms,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
  localparam int SUM_W = ADC_BITS + $clog2(SAMPLE_COUNT + 1);
  localparam logic [SUM_W-1:0] FULL = SUM_W'((2 ** ADC_BITS - 1) * SAMPLE_COUNT);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLE_COUNT - 1);

  localparam logic [1:0] REG_RS = 2'd0;
  localparam logic [1:0] REG_A  = 2'd1;
  localparam logic [1:0] REG_B  = 2'd2;
  localparam logic [1:0] REG_C  = 2'd3;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHECK = 5'd1;
  localparam logic [4:0] S_NUM   = 5'd2;
  localparam logic [4:0] S_RDIV0 = 5'd3;
  localparam logic [4:0] S_RDIV  = 5'd4;
  localparam logic [4:0] S_NORM  = 5'd5;
  localparam logic [4:0] S_SQ    = 5'd6;
  localparam logic [4:0] S_SQW   = 5'd7;
  localparam logic [4:0] S_LN    = 5'd8;
  localparam logic [4:0] S_LNW   = 5'd9;
  localparam logic [4:0] S_X2    = 5'd10;
  localparam logic [4:0] S_X2W   = 5'd11;
  localparam logic [4:0] S_X3    = 5'd12;
  localparam logic [4:0] S_X3W   = 5'd13;
  localparam logic [4:0] S_BX    = 5'd14;
  localparam logic [4:0] S_BXW   = 5'd15;
  localparam logic [4:0] S_CX    = 5'd16;
  localparam logic [4:0] S_CXW   = 5'd17;
  localparam logic [4:0] S_TST   = 5'd18;
  localparam logic [4:0] S_TDIV  = 5'd19;
  localparam logic [4:0] S_DONE  = 5'd20;

  logic [23:0] rs_r;
  logic [31:0] coef_a_r, coef_b_r, coef_c_r;
  logic [SUM_W-1:0] sum_r, csum_r, den_r;
  logic [CNT_W-1:0] cnt_r;
  logic [4:0]  state_r;
  logic [41:0] num_r, lx_r;
  logic [5:0]  sh_r, k_r;
  logic [30:0] m_r;
  logic [27:0] frac_r;
  logic [4:0]  it_r;
  logic        logsel_r;
  logic [33:0] l2num_r, mag_r;
  logic        xneg_r;
  logic [29:0] xmag_r;
  logic [35:0] x2_r;
  logic [31:0] x3_r;
  logic signed [49:0] s_r;
  logic [23:0] res_r;
  logic signed [15:0] temp_r;
  logic [1:0]  stat_r;
  logic        out_valid_r;
  logic signed [15:0] out_temp_r;
  logic [23:0] out_res_r;
  logic [1:0]  out_stat_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod_r;
  div_req_t           dreq;
  logic [DIV_W-1:0]   quot;
  logic               div_done;

  logic               in_acc, cfg_wr;
  logic [SUM_W-1:0]   sum_new;
  logic [23:0]        rs_eff;
  logic [31:0]        t_sq;
  logic [27:0]        frac_new;
  logic signed [34:0] l2_diff;
  logic [MUL_P_W-1:0] rnd33, rnd23, rnd31, rnd15;
  logic signed [49:0] bx_s, cx_s;
  logic [19:0]        q20;
  logic signed [20:0] tq;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign in_stall = state_r != S_IDLE;
  assign in_acc   = in_valid & ~in_stall;
  assign sum_new  = sum_r + SUM_W'(ADC_BITS'(in_adc_sample));
  assign rs_eff   = (rs_r == 24'd0) ? 24'd1 : rs_r;

  assign out_valid               = out_valid_r;
  assign out_temperature_centi_c = out_temp_r;
  assign out_resistance_ohms     = out_res_r;
  assign out_status              = out_stat_r;

  always_comb begin
    unique case (paddr[3:2])
      REG_RS:  prdata = {8'd0, rs_r};
      REG_A:   prdata = coef_a_r;
      REG_B:   prdata = coef_b_r;
      default: prdata = coef_c_r;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_CHECK: begin mul_a = MUL_A_W'(rs_eff);   mul_b = MUL_B_W'(csum_r); end
      S_SQ:    begin mul_a = MUL_A_W'(m_r);      mul_b = MUL_B_W'(m_r);    end
      S_LN:    begin mul_a = MUL_A_W'(mag_r);    mul_b = LN2_Q30;          end
      S_X2:    begin mul_a = MUL_A_W'(xmag_r);   mul_b = MUL_B_W'(xmag_r); end
      S_X3:    begin mul_a = x2_r;               mul_b = MUL_B_W'(xmag_r); end
      S_BX:    begin mul_a = MUL_A_W'(coef_b_r); mul_b = MUL_B_W'(xmag_r); end
      S_CX:    begin mul_a = MUL_A_W'(x3_r);     mul_b = coef_c_r;         end
      default: begin mul_a = '0;                 mul_b = '0;               end
    endcase
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    if (state_r == S_RDIV0) begin
      dreq.start    = 1'b1;
      dreq.dividend = DIV_W'({num_r, 1'b0}) + DIV_W'(den_r);
      dreq.divisor  = DIV_W'({den_r, 1'b0});
    end else if (state_r == S_TST && !s_r[49] && s_r != 50'sd0) begin
      dreq.start    = 1'b1;
      dreq.dividend = (DIV_W'(200) << 40) + DIV_W'(s_r);
      dreq.divisor  = {s_r[48:0], 1'b0};
    end
  end

  assign t_sq     = prod_r[61:30];
  assign frac_new = {frac_r[26:0], t_sq[31]};
  assign l2_diff  = $signed({1'b0, l2num_r}) - $signed({1'b0, k_r, frac_new});
  assign rnd33    = prod_r + (MUL_P_W'(1) << 33);
  assign rnd23    = prod_r + (MUL_P_W'(1) << 23);
  assign rnd31    = prod_r + (MUL_P_W'(1) << 31);
  assign rnd15    = prod_r + (MUL_P_W'(1) << 15);
  assign bx_s     = xneg_r ? -$signed(50'(rnd23[61:24])) : $signed(50'(rnd23[61:24]));
  assign cx_s     = xneg_r ? -$signed(50'(rnd15[63:16])) : $signed(50'(rnd15[63:16]));
  assign q20      = (quot > DIV_W'(Q_MAX)) ? Q_MAX : quot[19:0];
  assign tq       = $signed({1'b0, q20}) - 21'sd27315;

  thtc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  thtc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (dreq),
    .quot_r (quot),
    .done_r (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r     <= 24'd15300;
      coef_a_r <= 32'd998765346;
      coef_b_r <= 32'd273797624;
      coef_c_r <= 32'd214152;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RS:  rs_r     <= pwdata[23:0];
        REG_A:   coef_a_r <= pwdata;
        REG_B:   coef_b_r <= pwdata;
        default: coef_c_r <= pwdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE)
        out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (cnt_r == LAST) begin
              csum_r  <= sum_new;
              sum_r   <= '0;
              cnt_r   <= '0;
              state_r <= S_CHECK;
            end else begin
              sum_r <= sum_new;
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_CHECK: begin
          temp_r <= 16'sd0;
          if (csum_r == '0) begin
            stat_r  <= ST_ZERO;
            res_r   <= 24'd0;
            state_r <= S_DONE;
          end else if (csum_r >= FULL) begin
            stat_r  <= ST_FULL;
            res_r   <= R_MAX;
            state_r <= S_DONE;
          end else begin
            stat_r  <= ST_OK;
            state_r <= S_NUM;
          end
        end
        S_NUM: begin
          num_r   <= prod_r[41:0];
          den_r   <= FULL - csum_r;
          state_r <= S_RDIV0;
        end
        S_RDIV0: state_r <= S_RDIV;
        S_RDIV: begin
          if (div_done) begin
            res_r    <= (quot > DIV_W'(R_MAX)) ? R_MAX : quot[23:0];
            lx_r     <= num_r;
            sh_r     <= '0;
            logsel_r <= 1'b0;
            state_r  <= S_NORM;
          end
        end
        S_NORM: begin
          if (lx_r[41]) begin
            m_r     <= lx_r[41:11];
            k_r     <= 6'd41 - sh_r;
            frac_r  <= '0;
            it_r    <= '0;
            state_r <= S_SQ;
          end else begin
            lx_r <= {lx_r[40:0], 1'b0};
            sh_r <= sh_r + 1'b1;
          end
        end
        S_SQ: state_r <= S_SQW;
        S_SQW: begin
          // mantissa squared in Q1.30; an overflow past 2 gives a one bit
          m_r    <= t_sq[31] ? t_sq[31:1] : t_sq[30:0];
          frac_r <= frac_new;
          it_r   <= it_r + 1'b1;
          if (it_r == 5'd27) begin
            if (!logsel_r) begin
              l2num_r  <= {k_r, frac_new};
              lx_r     <= 42'(den_r);
              sh_r     <= '0;
              logsel_r <= 1'b1;
              state_r  <= S_NORM;
            end else begin
              xneg_r  <= l2_diff[34];
              mag_r   <= l2_diff[34] ? 34'(-l2_diff) : l2_diff[33:0];
              state_r <= S_LN;
            end
          end else begin
            state_r <= S_SQ;
          end
        end
        S_LN:  state_r <= S_LNW;
        S_LNW: begin
          xmag_r  <= rnd33[63:34];
          state_r <= S_X2;
        end
        S_X2:  state_r <= S_X2W;
        S_X2W: begin
          x2_r    <= 36'(rnd23[58:24]);
          state_r <= S_X3;
        end
        S_X3:  state_r <= S_X3W;
        S_X3W: begin
          x3_r    <= rnd31[63:32];
          state_r <= S_BX;
        end
        S_BX:  state_r <= S_BXW;
        S_BXW: begin
          s_r     <= $signed(50'(coef_a_r)) + bx_s;
          state_r <= S_CX;
        end
        S_CX:  state_r <= S_CXW;
        S_CXW: begin
          s_r     <= s_r + cx_s;
          state_r <= S_TST;
        end
        S_TST: begin
          if (s_r[49] || s_r == 50'sd0) begin
            temp_r  <= T_MAX;
            state_r <= S_DONE;
          end else begin
            state_r <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_done) begin
            if (tq > 21'(T_MAX))
              temp_r <= T_MAX;
            else if (tq < 21'(T_MIN))
              temp_r <= T_MIN;
            else
              temp_r <= tq[15:0];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_temp_r  <= temp_r;
            out_res_r   <= res_r;
            out_stat_r  <= stat_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r == ST_ZERO) |-> (out_res_r == 24'd0 && out_temp_r == 16'sd0))
    else $error("zero-sum item carries non-zero fields");

  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r == ST_FULL) |-> (out_res_r == R_MAX && out_temp_r == 16'sd0))
    else $error("full-scale item carries wrong fields");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_temp_r <= T_MAX && out_temp_r >= T_MIN))
    else $error("temperature outside saturation range");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST)
    else $error("sample count overran the group size");

  a_group_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cnt_r == LAST) |=> (state_r == S_CHECK && sum_r == '0))
    else $error("last sample of a group did not start a conversion");

endmodule

FILE: rtl/thtc_mul.sv
// Shared unsigned multiplier with registered product.
module thtc_mul
  import thtc_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

FILE: rtl/thtc_div.sv
// Restoring divider, one quotient bit per cycle.
module thtc_div
  import thtc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic [DIV_W-1:0] quot_r,
  output logic             done_r
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W:0]   rem_r;
  logic [DIV_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_r[DIV_W-1:0], quot_r[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
        rem_r  <= '0;
        quot_r <= req.dividend;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r  <= fits ? rem_sh - {1'b0, dsr_r} : rem_sh;
        quot_r <= {quot_r[DIV_W-2:0], fits};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
